// File: design/fssm_pkg.sv
// ----------------------------------------------------------------------------
// fssm_pkg
// Types and codes shared by the frame scheduler state machine.
// ----------------------------------------------------------------------------
package fssm_pkg;

  // event codes
  typedef enum logic [4:0] {
    OP_PERFORM        = 5'd0,
    OP_ENTER_FRAME    = 5'd1,
    OP_LEAVE_FRAME    = 5'd2,
    OP_VISIBLE        = 5'd3,
    OP_NEEDS_REDRAW   = 5'd4,
    OP_INCOMPLETE     = 5'd5,
    OP_DRAW_DONE      = 5'd6,
    OP_NEEDS_COMMIT   = 5'd7,
    OP_READBACK       = 5'd8,
    OP_FINISH_COMMIT  = 5'd9,
    OP_FRAME_ABORTED  = 5'd10,
    OP_SURFACE_LOST   = 5'd11,
    OP_READY_ACTIVATE = 5'd12,
    OP_CAN_DRAW       = 5'd13,
    OP_SURFACE_MADE   = 5'd14,
    OP_TEXTURE_REQ    = 5'd15,
    OP_CAN_START      = 5'd16,
    OP_QUERY          = 5'd17
  } op_t;

  // action codes
  typedef enum logic [3:0] {
    ACT_NONE           = 4'd0,
    ACT_BEGIN_FRAME    = 4'd1,
    ACT_COMMIT         = 4'd2,
    ACT_UPDATE_TILES   = 4'd3,
    ACT_ACTIVATE       = 4'd4,
    ACT_DRAW_POSSIBLE  = 4'd5,
    ACT_DRAW_FORCED    = 4'd6,
    ACT_DRAW_ABORT     = 4'd7,
    ACT_DRAW_READBACK  = 4'd8,
    ACT_CREATE_SURFACE = 4'd9,
    ACT_ACQUIRE_TEX    = 4'd10
  } action_t;

  typedef enum logic [1:0] {
    CFG_IMPL_SIDE  = 2'd0,
    CFG_FORCE_DRAW = 2'd1,
    CFG_MAX_FAILS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SURF_ACTIVE      = 3'd0,
    SURF_LOST        = 3'd1,
    SURF_CREATING    = 3'd2,
    SURF_WAIT_COMMIT = 3'd3,
    SURF_WAIT_ACT    = 3'd4
  } surf_t;

  typedef enum logic [1:0] {
    CP_IDLE        = 2'd0,
    CP_IN_PROGRESS = 2'd1,
    CP_READY       = 2'd2,
    CP_WAIT_DRAW   = 2'd3
  } commit_t;

  typedef enum logic [1:0] {
    TEX_UNLOCKED = 2'd0,
    TEX_MAIN     = 2'd1,
    TEX_IMPL     = 2'd2
  } tex_t;

  typedef enum logic [1:0] {
    FR_IDLE        = 2'd0,
    FR_WAIT_COMMIT = 2'd1,
    FR_WAIT_ACT    = 2'd2,
    FR_WAIT_DRAW   = 2'd3
  } forced_t;

  typedef enum logic [2:0] {
    RB_IDLE             = 3'd0,
    RB_NEEDS_BEGIN      = 3'd1,
    RB_WAIT_COMMIT      = 3'd2,
    RB_WAIT_ACT         = 3'd3,
    RB_WAIT_DRAW        = 3'd4,
    RB_WAIT_REPL_COMMIT = 3'd5,
    RB_WAIT_REPL_ACT    = 3'd6
  } readback_t;

  // status flag bit positions
  localparam int FlagBits       = 13;
  localparam int F_NEEDS_REDRAW = 0;
  localparam int F_INCOMPLETE   = 1;
  localparam int F_NEEDS_COMMIT = 2;
  localparam int F_TEX_WANTED   = 3;
  localparam int F_INSIDE_FRAME = 4;
  localparam int F_VISIBLE      = 5;
  localparam int F_CAN_START    = 6;
  localparam int F_CAN_DRAW     = 7;
  localparam int F_PENDING      = 8;
  localparam int F_PENDING_RDY  = 9;
  localparam int F_FIRST_DRAW   = 10;
  localparam int F_DRAW_FAILED  = 11;
  localparam int F_SURFACE_INIT = 12;

  localparam logic [7:0] MaxFailsReset = 8'd3;
  localparam logic [7:0] FailCountMax  = 8'd255;

  typedef struct packed {
    surf_t                 surf;
    commit_t               cp;
    tex_t                  tex;
    forced_t               fr;
    readback_t             rb;
    logic [7:0]            fails;
    logic                  swapped;
    logic                  tiles_done;
    logic                  begin_sent;
    logic [FlagBits-1:0]   flags;
  } sched_state_t;

  typedef struct packed {
    action_t    next_step;
    logic       begin_frame_needed;
    logic       proactive_begin_frame;
    logic [1:0] commit_phase;
    logic [2:0] surface_phase;
  } result_t;

endpackage

// File: design/frame_scheduler_state_machine_top.sv
// ----------------------------------------------------------------------------
// frame_scheduler_state_machine_top
// Display frame scheduler: takes one event per item, updates the surface,
// commit, texture, forced-redraw and readback sub-states and reports the
// prioritized next action.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   in       | in_valid / in_stall        | op, action, flag
//   out      | out_valid / out_stall      | next_step, begin_frame_needed,
//            |                            | proactive_begin_frame, commit_phase,
//            |                            | surface_phase
//   cfg      | cfg_write                  | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the state update and the result
// are computed in the cycle of acceptance. the result is registered in the
// result register, or in the skid register while the result register holds
// one not yet taken, so the input stalls only when both hold untaken results.
// rst is synchronous and clears the state, config registers and both valids.
// ----------------------------------------------------------------------------
module frame_scheduler_state_machine_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [4:0]           op,
  input  logic [3:0]           action,
  input  logic                 flag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           next_step,
  output logic                 begin_frame_needed,
  output logic                 proactive_begin_frame,
  output logic [1:0]           commit_phase,
  output logic [2:0]           surface_phase
);
  import fssm_pkg::*;

  logic         pending_tree_mode;
  logic         force_draw_on_checkerboard;
  logic [7:0]   max_failed_draws;

  sched_state_t state;
  sched_state_t state_next;
  result_t      res_next;
  result_t      head;
  result_t      skid;
  logic         skid_valid;
  logic         in_acc;
  logic         out_take;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid & ~skid_valid;
  assign out_take = out_valid & ~out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_tree_mode          <= 1'b0;
      force_draw_on_checkerboard <= 1'b0;
      max_failed_draws           <= MaxFailsReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMPL_SIDE:  pending_tree_mode          <= cfg_data[0];
        CFG_FORCE_DRAW: force_draw_on_checkerboard <= cfg_data[0];
        CFG_MAX_FAILS:  max_failed_draws           <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state and result for the item at the input
  always_comb begin
    sched_state_t st;
    logic do_commit;
    logic abrt;
    logic do_act;
    logic do_draw;
    logic swp;
    logic pend;
    logic has_surf;
    logic force_act;
    logic abort_dr;
    logic draw;
    logic want_begin;
    logic need;
    action_t na;

    st        = state;
    do_commit = 1'b0;
    abrt      = 1'b0;
    do_act    = 1'b0;
    do_draw   = 1'b0;
    swp       = 1'b0;

    unique case (op)
      OP_PERFORM: begin
        unique case (action)
          ACT_BEGIN_FRAME: begin
            st.cp = CP_IN_PROGRESS;
            st.flags[F_NEEDS_COMMIT] = 1'b0;
            if (st.rb == RB_NEEDS_BEGIN) st.rb = RB_WAIT_COMMIT;
            st.begin_sent = 1'b1;
          end
          ACT_COMMIT:         do_commit = 1'b1;
          ACT_UPDATE_TILES:   st.tiles_done = 1'b1;
          ACT_ACTIVATE:       do_act = 1'b1;
          ACT_DRAW_POSSIBLE,
          ACT_DRAW_FORCED: begin
            do_draw = 1'b1;
            swp     = 1'b1;
          end
          ACT_DRAW_ABORT,
          ACT_DRAW_READBACK:  do_draw = 1'b1;
          ACT_CREATE_SURFACE: st.surf = SURF_CREATING;
          ACT_ACQUIRE_TEX: begin
            st.tex = TEX_MAIN;
            st.flags[F_TEX_WANTED] = 1'b0;
          end
          default: ;
        endcase
      end
      OP_ENTER_FRAME: begin
        st.swapped    = 1'b0;
        st.tiles_done = 1'b0;
        st.begin_sent = 1'b0;
        st.flags[F_INSIDE_FRAME] = 1'b1;
      end
      OP_LEAVE_FRAME:  st.flags[F_INSIDE_FRAME] = 1'b0;
      OP_VISIBLE:      st.flags[F_VISIBLE] = flag;
      OP_NEEDS_REDRAW: st.flags[F_NEEDS_REDRAW] = 1'b1;
      OP_INCOMPLETE:   st.flags[F_INCOMPLETE] = flag;
      OP_DRAW_DONE: begin
        st.flags[F_DRAW_FAILED] = ~flag;
        if (flag) begin
          st.fails = '0;
        end else begin
          st.flags[F_NEEDS_REDRAW] = 1'b1;
          st.flags[F_NEEDS_COMMIT] = 1'b1;
          if (st.fails != FailCountMax) st.fails = st.fails + 8'd1;
          if (force_draw_on_checkerboard && (st.fails >= max_failed_draws)) begin
            st.fails = '0;
            st.fr    = FR_WAIT_COMMIT;
          end
        end
      end
      OP_NEEDS_COMMIT: st.flags[F_NEEDS_COMMIT] = 1'b1;
      OP_READBACK:
        st.rb = (st.cp == CP_IN_PROGRESS) ? RB_WAIT_COMMIT : RB_NEEDS_BEGIN;
      OP_FINISH_COMMIT: st.cp = CP_READY;
      OP_FRAME_ABORTED: begin
        if (flag) begin
          do_commit = 1'b1;
          abrt      = 1'b1;
        end else begin
          st.cp = CP_IDLE;
          st.flags[F_NEEDS_COMMIT] = 1'b1;
        end
      end
      OP_SURFACE_LOST: begin
        if (st.surf != SURF_LOST && st.surf != SURF_CREATING) begin
          st.surf = SURF_LOST;
          st.flags[F_NEEDS_REDRAW] = 1'b0;
        end
      end
      OP_READY_ACTIVATE:
        if (st.flags[F_PENDING]) st.flags[F_PENDING_RDY] = 1'b1;
      OP_CAN_DRAW: st.flags[F_CAN_DRAW] = flag;
      OP_SURFACE_MADE: begin
        st.surf = SURF_WAIT_COMMIT;
        if (st.flags[F_SURFACE_INIT]) st.flags[F_NEEDS_COMMIT] = 1'b1;
        st.flags[F_SURFACE_INIT] = 1'b1;
      end
      OP_TEXTURE_REQ: st.flags[F_TEX_WANTED] = 1'b1;
      OP_CAN_START:   st.flags[F_CAN_START] = flag;
      default: ;
    endcase

    // commit finished or aborted with handling
    pend = pending_tree_mode & ~abrt;
    if (do_commit) begin
      st.flags[F_PENDING] = pend;
      if (st.rb == RB_WAIT_COMMIT)
        st.rb = pend ? RB_WAIT_ACT : RB_WAIT_DRAW;
      else if (st.rb == RB_WAIT_REPL_COMMIT)
        st.rb = pend ? RB_WAIT_REPL_ACT : RB_IDLE;
      if (st.rb == RB_IDLE || st.rb == RB_WAIT_REPL_ACT) begin
        if (st.fr == FR_WAIT_COMMIT) st.fr = pend ? FR_WAIT_ACT : FR_WAIT_DRAW;
        if (st.surf == SURF_WAIT_COMMIT) begin
          if (pend) begin
            st.surf = SURF_WAIT_ACT;
          end else begin
            st.surf = SURF_ACTIVE;
            st.flags[F_NEEDS_REDRAW] = 1'b1;
          end
        end
      end
      if (!abrt || st.rb != RB_IDLE || st.fr != FR_IDLE) st.cp = CP_WAIT_DRAW;
      else st.cp = CP_IDLE;
      if (!pend && (!abrt || st.rb == RB_WAIT_DRAW || st.fr == FR_WAIT_DRAW)) begin
        st.flags[F_NEEDS_REDRAW] = 1'b1;
        st.flags[F_FIRST_DRAW]   = 1'b1;
      end
      st.flags[F_PENDING_RDY] = 1'b0;
      if (st.flags[F_DRAW_FAILED]) st.swapped = 1'b0;
      st.tex = (pend || st.flags[F_NEEDS_REDRAW]) ? TEX_IMPL : TEX_UNLOCKED;
    end

    if (do_act) begin
      if (st.surf == SURF_WAIT_ACT) st.surf = SURF_ACTIVE;
      if (st.fr == FR_WAIT_ACT) st.fr = FR_WAIT_DRAW;
      if (st.rb == RB_WAIT_ACT) st.rb = RB_WAIT_DRAW;
      else if (st.rb == RB_WAIT_REPL_ACT) st.rb = RB_IDLE;
      st.flags[F_PENDING]      = 1'b0;
      st.flags[F_PENDING_RDY]  = 1'b0;
      st.flags[F_FIRST_DRAW]   = 1'b1;
      st.flags[F_NEEDS_REDRAW] = 1'b1;
    end

    if (do_draw) begin
      priority if (st.rb == RB_WAIT_DRAW) begin
        st.cp = CP_IN_PROGRESS;
        st.rb = RB_WAIT_REPL_COMMIT;
      end else if (st.fr == FR_WAIT_DRAW) begin
        st.cp = CP_IDLE;
        st.fr = FR_IDLE;
      end else if (st.cp == CP_WAIT_DRAW && !st.flags[F_PENDING]) begin
        st.cp = CP_IDLE;
      end
      if (st.tex == TEX_IMPL) st.tex = TEX_UNLOCKED;
      st.flags[F_NEEDS_REDRAW] = 1'b0;
      st.flags[F_DRAW_FAILED]  = 1'b0;
      st.flags[F_FIRST_DRAW]   = 1'b0;
      if (swp) st.swapped = 1'b1;
    end

    state_next = st;

    // result from the updated state
    has_surf  = (st.surf == SURF_ACTIVE) || (st.surf == SURF_WAIT_COMMIT) ||
                (st.surf == SURF_WAIT_ACT);
    force_act = (st.tex == TEX_MAIN) || (st.surf == SURF_LOST);
    abort_dr  = force_act || !st.flags[F_CAN_DRAW] || !st.flags[F_VISIBLE];

    priority if (st.rb == RB_WAIT_REPL_COMMIT || st.rb == RB_WAIT_REPL_ACT) draw = 1'b0;
    else if (st.rb == RB_WAIT_DRAW)                      draw = 1'b1;
    else if (abort_dr)                                   draw = st.flags[F_FIRST_DRAW];
    else if (st.swapped || !st.flags[F_INSIDE_FRAME])    draw = 1'b0;
    else if (st.fr == FR_WAIT_DRAW)                      draw = 1'b1;
    else                                                 draw = st.flags[F_NEEDS_REDRAW];

    priority if (!st.flags[F_NEEDS_COMMIT] || st.cp != CP_IDLE || st.flags[F_PENDING])
      want_begin = 1'b0;
    else if (st.rb == RB_NEEDS_BEGIN) want_begin = 1'b1;
    else if (!st.flags[F_VISIBLE])    want_begin = 1'b0;
    else if (st.surf == SURF_WAIT_COMMIT || st.fr == FR_WAIT_COMMIT) want_begin = 1'b1;
    else if (st.begin_sent)           want_begin = 1'b0;
    else                              want_begin = has_surf;

    priority if (st.flags[F_TEX_WANTED] && st.tex == TEX_UNLOCKED)
      na = ACT_ACQUIRE_TEX;
    else if (pending_tree_mode && !st.tiles_done && has_surf &&
             (draw || st.flags[F_INCOMPLETE]))
      na = ACT_UPDATE_TILES;
    else if (st.flags[F_PENDING] && !st.flags[F_FIRST_DRAW] &&
             (force_act || st.flags[F_PENDING_RDY]))
      na = ACT_ACTIVATE;
    else if (st.cp == CP_READY)
      na = ACT_COMMIT;
    else if (draw) begin
      priority if (st.rb == RB_WAIT_DRAW) na = ACT_DRAW_READBACK;
      else if (abort_dr)                  na = ACT_DRAW_ABORT;
      else if (st.fr == FR_WAIT_DRAW)     na = ACT_DRAW_FORCED;
      else                                na = ACT_DRAW_POSSIBLE;
    end else if (want_begin)
      na = ACT_BEGIN_FRAME;
    else if (st.flags[F_CAN_START] && st.cp == CP_IDLE && !st.flags[F_FIRST_DRAW] &&
             !st.flags[F_PENDING] && st.surf == SURF_LOST)
      na = ACT_CREATE_SURFACE;
    else
      na = ACT_NONE;

    priority if (!has_surf || !st.flags[F_CAN_DRAW]) need = 1'b0;
    else if (st.fr == FR_WAIT_DRAW)                  need = 1'b1;
    else if (!st.flags[F_VISIBLE])                   need = 1'b0;
    else need = st.flags[F_INCOMPLETE] | st.flags[F_NEEDS_REDRAW];

    res_next.next_step             = na;
    res_next.begin_frame_needed    = need;
    res_next.proactive_begin_frame = has_surf && st.flags[F_VISIBLE] &&
      (st.flags[F_NEEDS_COMMIT] || st.cp != CP_IDLE || st.flags[F_PENDING]);
    res_next.commit_phase          = st.cp;
    res_next.surface_phase         = st.surf;
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.surf       <= SURF_LOST;
      state.cp         <= CP_IDLE;
      state.tex        <= TEX_UNLOCKED;
      state.fr         <= FR_IDLE;
      state.rb         <= RB_IDLE;
      state.fails      <= '0;
      state.swapped    <= 1'b0;
      state.tiles_done <= 1'b0;
      state.begin_sent <= 1'b0;
      state.flags      <= '0;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_acc;
        end
      end else if (in_acc) begin
        if (out_valid) skid_valid <= 1'b1;
        else           out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid) begin
      head <= skid;
    end else if (in_acc && (out_take || !out_valid)) begin
      head <= res_next;
    end
    if (in_acc && out_valid && !out_take) begin
      skid <= res_next;
    end
  end

  assign next_step             = head.next_step;
  assign begin_frame_needed    = head.begin_frame_needed;
  assign proactive_begin_frame = head.proactive_begin_frame;
  assign commit_phase          = head.commit_phase;
  assign surface_phase         = head.surface_phase;

endmodule

// File: bench/frame_scheduler_state_machine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_scheduler_state_machine_top_tb
// Self-checking bench for the frame scheduler. Events go in through the
// valid/stall channel and a behavioral copy of the scheduler predicts the
// decision for each one. Decisions coming out are matched in order. The run
// covers directed corner events, failed-draw saturation and weighted random
// traffic that often follows the recommended action, under several
// register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module frame_scheduler_state_machine_top_tb;
  import fssm_pkg::*;

  localparam logic [4:0] OpUnknownLow  = 5'd18;
  localparam logic [4:0] OpUnknownHigh = 5'd31;
  localparam logic [3:0] ActUnknown    = 4'd15;
  localparam int         ReportLimit   = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_IMPL_SIDE;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [4:0] op = OP_QUERY;
  logic [3:0] action = ACT_NONE;
  logic       flag = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] next_step;
  logic       begin_frame_needed;
  logic       proactive_begin_frame;
  logic [1:0] commit_phase;
  logic [2:0] surface_phase;

  frame_scheduler_state_machine_top DUT (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .op                    (op),
    .action                (action),
    .flag                  (flag),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .next_step             (next_step),
    .begin_frame_needed    (begin_frame_needed),
    .proactive_begin_frame (proactive_begin_frame),
    .commit_phase          (commit_phase),
    .surface_phase         (surface_phase)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scheduler copy used for prediction
  logic                impl_cfg = 1'b0;
  logic                force_cfg = 1'b0;
  logic [7:0]          max_fails_cfg = MaxFailsReset;
  surf_t               surf_st = SURF_LOST;
  commit_t             commit_st = CP_IDLE;
  tex_t                tex_st = TEX_UNLOCKED;
  forced_t             forced_st = FR_IDLE;
  readback_t           rb_st = RB_IDLE;
  logic [7:0]          fail_run = 8'd0;
  logic                swapped = 1'b0;
  logic                tiles_done = 1'b0;
  logic                begin_sent = 1'b0;
  logic [FlagBits-1:0] flags = '0;

  result_t decisions_due[$];
  int      mismatch_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;

  function automatic logic has_surf();
    return surf_st == SURF_ACTIVE || surf_st == SURF_WAIT_COMMIT ||
           surf_st == SURF_WAIT_ACT;
  endfunction

  function automatic logic forced_act();
    return tex_st == TEX_MAIN || surf_st == SURF_LOST;
  endfunction

  function automatic logic abort_now();
    return forced_act() || !flags[F_CAN_DRAW] || !flags[F_VISIBLE];
  endfunction

  function automatic action_t choose_action();
    logic draw;
    logic beg;
    if (rb_st == RB_WAIT_REPL_COMMIT || rb_st == RB_WAIT_REPL_ACT) draw = 1'b0;
    else if (rb_st == RB_WAIT_DRAW) draw = 1'b1;
    else if (abort_now()) draw = flags[F_FIRST_DRAW];
    else if (swapped || !flags[F_INSIDE_FRAME]) draw = 1'b0;
    else if (forced_st == FR_WAIT_DRAW) draw = 1'b1;
    else draw = flags[F_NEEDS_REDRAW];

    if (!flags[F_NEEDS_COMMIT] || commit_st != CP_IDLE || flags[F_PENDING]) beg = 1'b0;
    else if (rb_st == RB_NEEDS_BEGIN) beg = 1'b1;
    else if (!flags[F_VISIBLE]) beg = 1'b0;
    else if (surf_st == SURF_WAIT_COMMIT || forced_st == FR_WAIT_COMMIT) beg = 1'b1;
    else beg = !begin_sent && has_surf();

    if (flags[F_TEX_WANTED] && tex_st == TEX_UNLOCKED) return ACT_ACQUIRE_TEX;
    if (impl_cfg && !tiles_done && has_surf() && (draw || flags[F_INCOMPLETE]))
      return ACT_UPDATE_TILES;
    if (flags[F_PENDING] && !flags[F_FIRST_DRAW] &&
        (forced_act() || flags[F_PENDING_RDY]))
      return ACT_ACTIVATE;
    if (commit_st == CP_READY) return ACT_COMMIT;
    if (draw) begin
      if (rb_st == RB_WAIT_DRAW) return ACT_DRAW_READBACK;
      if (abort_now()) return ACT_DRAW_ABORT;
      if (forced_st == FR_WAIT_DRAW) return ACT_DRAW_FORCED;
      return ACT_DRAW_POSSIBLE;
    end
    if (beg) return ACT_BEGIN_FRAME;
    if (flags[F_CAN_START] && commit_st == CP_IDLE && !flags[F_FIRST_DRAW] &&
        !flags[F_PENDING] && surf_st == SURF_LOST)
      return ACT_CREATE_SURFACE;
    return ACT_NONE;
  endfunction

  // commit done, or frame aborted with the abort handled
  function automatic void land_commit(input logic aborted);
    logic pend;
    pend = impl_cfg && !aborted;
    flags[F_PENDING] = pend;
    if (rb_st == RB_WAIT_COMMIT) begin
      if (pend) rb_st = RB_WAIT_ACT;
      else rb_st = RB_WAIT_DRAW;
    end else if (rb_st == RB_WAIT_REPL_COMMIT) begin
      if (pend) rb_st = RB_WAIT_REPL_ACT;
      else rb_st = RB_IDLE;
    end
    if (rb_st == RB_IDLE || rb_st == RB_WAIT_REPL_ACT) begin
      if (forced_st == FR_WAIT_COMMIT) begin
        if (pend) forced_st = FR_WAIT_ACT;
        else forced_st = FR_WAIT_DRAW;
      end
      if (surf_st == SURF_WAIT_COMMIT) begin
        if (pend) begin
          surf_st = SURF_WAIT_ACT;
        end else begin
          surf_st = SURF_ACTIVE;
          flags[F_NEEDS_REDRAW] = 1'b1;
        end
      end
    end
    if (!aborted || rb_st != RB_IDLE || forced_st != FR_IDLE) commit_st = CP_WAIT_DRAW;
    else commit_st = CP_IDLE;
    if (!pend && (!aborted || rb_st == RB_WAIT_DRAW || forced_st == FR_WAIT_DRAW)) begin
      flags[F_NEEDS_REDRAW] = 1'b1;
      flags[F_FIRST_DRAW]   = 1'b1;
    end
    flags[F_PENDING_RDY] = 1'b0;
    if (flags[F_DRAW_FAILED]) swapped = 1'b0;
    if (pend || flags[F_NEEDS_REDRAW]) tex_st = TEX_IMPL;
    else tex_st = TEX_UNLOCKED;
  endfunction

  function automatic void land_draw(input logic swap_seen);
    if (rb_st == RB_WAIT_DRAW) begin
      commit_st = CP_IN_PROGRESS;
      rb_st     = RB_WAIT_REPL_COMMIT;
    end else if (forced_st == FR_WAIT_DRAW) begin
      commit_st = CP_IDLE;
      forced_st = FR_IDLE;
    end else if (commit_st == CP_WAIT_DRAW && !flags[F_PENDING]) begin
      commit_st = CP_IDLE;
    end
    if (tex_st == TEX_IMPL) tex_st = TEX_UNLOCKED;
    flags[F_NEEDS_REDRAW] = 1'b0;
    flags[F_DRAW_FAILED]  = 1'b0;
    flags[F_FIRST_DRAW]   = 1'b0;
    if (swap_seen) swapped = 1'b1;
  endfunction

  // applies one event and returns the decision the block should report
  function automatic result_t schedule_event(input logic [4:0] ev_op,
                                             input logic [3:0] ev_act,
                                             input logic ev_flag);
    result_t r;
    logic    need;
    case (ev_op)
      OP_PERFORM: begin
        case (ev_act)
          ACT_BEGIN_FRAME: begin
            commit_st = CP_IN_PROGRESS;
            flags[F_NEEDS_COMMIT] = 1'b0;
            if (rb_st == RB_NEEDS_BEGIN) rb_st = RB_WAIT_COMMIT;
            begin_sent = 1'b1;
          end
          ACT_COMMIT:       land_commit(1'b0);
          ACT_UPDATE_TILES: tiles_done = 1'b1;
          ACT_ACTIVATE: begin
            if (surf_st == SURF_WAIT_ACT) surf_st = SURF_ACTIVE;
            if (forced_st == FR_WAIT_ACT) forced_st = FR_WAIT_DRAW;
            if (rb_st == RB_WAIT_ACT) rb_st = RB_WAIT_DRAW;
            else if (rb_st == RB_WAIT_REPL_ACT) rb_st = RB_IDLE;
            flags[F_PENDING]      = 1'b0;
            flags[F_PENDING_RDY]  = 1'b0;
            flags[F_FIRST_DRAW]   = 1'b1;
            flags[F_NEEDS_REDRAW] = 1'b1;
          end
          ACT_DRAW_POSSIBLE, ACT_DRAW_FORCED: land_draw(1'b1);
          ACT_DRAW_ABORT, ACT_DRAW_READBACK:  land_draw(1'b0);
          ACT_CREATE_SURFACE: surf_st = SURF_CREATING;
          ACT_ACQUIRE_TEX: begin
            tex_st = TEX_MAIN;
            flags[F_TEX_WANTED] = 1'b0;
          end
          default: ;
        endcase
      end
      OP_ENTER_FRAME: begin
        swapped    = 1'b0;
        tiles_done = 1'b0;
        begin_sent = 1'b0;
        flags[F_INSIDE_FRAME] = 1'b1;
      end
      OP_LEAVE_FRAME:  flags[F_INSIDE_FRAME] = 1'b0;
      OP_VISIBLE:      flags[F_VISIBLE] = ev_flag;
      OP_NEEDS_REDRAW: flags[F_NEEDS_REDRAW] = 1'b1;
      OP_INCOMPLETE:   flags[F_INCOMPLETE] = ev_flag;
      OP_DRAW_DONE: begin
        flags[F_DRAW_FAILED] = !ev_flag;
        if (ev_flag) begin
          fail_run = 8'd0;
        end else begin
          flags[F_NEEDS_REDRAW] = 1'b1;
          flags[F_NEEDS_COMMIT] = 1'b1;
          // saturate first, then test the threshold
          if (fail_run != FailCountMax) fail_run = fail_run + 8'd1;
          if (force_cfg && fail_run >= max_fails_cfg) begin
            fail_run  = 8'd0;
            forced_st = FR_WAIT_COMMIT;
          end
        end
      end
      OP_NEEDS_COMMIT: flags[F_NEEDS_COMMIT] = 1'b1;
      OP_READBACK: begin
        if (commit_st == CP_IN_PROGRESS) rb_st = RB_WAIT_COMMIT;
        else rb_st = RB_NEEDS_BEGIN;
      end
      OP_FINISH_COMMIT: commit_st = CP_READY;
      OP_FRAME_ABORTED: begin
        if (ev_flag) begin
          land_commit(1'b1);
        end else begin
          commit_st = CP_IDLE;
          flags[F_NEEDS_COMMIT] = 1'b1;
        end
      end
      OP_SURFACE_LOST: begin
        if (surf_st != SURF_LOST && surf_st != SURF_CREATING) begin
          surf_st = SURF_LOST;
          flags[F_NEEDS_REDRAW] = 1'b0;
        end
      end
      OP_READY_ACTIVATE: if (flags[F_PENDING]) flags[F_PENDING_RDY] = 1'b1;
      OP_CAN_DRAW:       flags[F_CAN_DRAW] = ev_flag;
      OP_SURFACE_MADE: begin
        surf_st = SURF_WAIT_COMMIT;
        if (flags[F_SURFACE_INIT]) flags[F_NEEDS_COMMIT] = 1'b1;
        flags[F_SURFACE_INIT] = 1'b1;
      end
      OP_TEXTURE_REQ: flags[F_TEX_WANTED] = 1'b1;
      OP_CAN_START:   flags[F_CAN_START] = ev_flag;
      default: ;
    endcase

    if (!has_surf() || !flags[F_CAN_DRAW]) need = 1'b0;
    else if (forced_st == FR_WAIT_DRAW) need = 1'b1;
    else if (!flags[F_VISIBLE]) need = 1'b0;
    else need = flags[F_INCOMPLETE] || flags[F_NEEDS_REDRAW];

    r.next_step             = choose_action();
    r.begin_frame_needed    = need;
    r.proactive_begin_frame = has_surf() && flags[F_VISIBLE] &&
                              (flags[F_NEEDS_COMMIT] || commit_st != CP_IDLE ||
                               flags[F_PENDING]);
    r.commit_phase          = commit_st;
    r.surface_phase         = surf_st;
    return r;
  endfunction

  // receiver side: random stall per cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // decision checker
  always @(posedge clk) begin
    result_t exp_r;
    result_t got_r;
    if (!rst && out_valid && !out_stall) begin
      got_r.next_step             = action_t'(next_step);
      got_r.begin_frame_needed    = begin_frame_needed;
      got_r.proactive_begin_frame = proactive_begin_frame;
      got_r.commit_phase          = commit_phase;
      got_r.surface_phase         = surface_phase;
      if (decisions_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: unexpected decision act=%0d need=%b pro=%b cp=%0d surf=%0d",
                   $realtime, got_r.next_step, got_r.begin_frame_needed,
                   got_r.proactive_begin_frame, got_r.commit_phase, got_r.surface_phase);
      end else begin
        exp_r = decisions_due.pop_front();
        if (got_r.next_step !== exp_r.next_step ||
            got_r.begin_frame_needed !== exp_r.begin_frame_needed ||
            got_r.proactive_begin_frame !== exp_r.proactive_begin_frame ||
            got_r.commit_phase !== exp_r.commit_phase ||
            got_r.surface_phase !== exp_r.surface_phase) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display({"%0t: decision differs: exp act=%0d need=%b pro=%b cp=%0d surf=%0d",
                      " / got act=%0d need=%b pro=%b cp=%0d surf=%0d"},
                     $realtime, exp_r.next_step, exp_r.begin_frame_needed,
                     exp_r.proactive_begin_frame, exp_r.commit_phase, exp_r.surface_phase,
                     got_r.next_step, got_r.begin_frame_needed,
                     got_r.proactive_begin_frame, got_r.commit_phase, got_r.surface_phase);
        end
      end
    end
  end

  // one event item; returns right after the edge that takes it
  task automatic send_item(input logic [4:0] ev_op, input logic [3:0] ev_act,
                           input logic ev_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= ev_op;
    action   <= ev_act;
    flag     <= ev_flag;
    do @(posedge clk); while (in_stall);
    decisions_due.push_back(schedule_event(ev_op, ev_act, ev_flag));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic impl, input logic force_on, input logic [7:0] max_f);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IMPL_SIDE;
    cfg_data  <= {7'd0, impl};
    @(posedge clk);
    cfg_index <= CFG_FORCE_DRAW;
    cfg_data  <= {7'd0, force_on};
    @(posedge clk);
    cfg_index <= CFG_MAX_FAILS;
    cfg_data  <= max_f;
    @(posedge clk);
    cfg_write <= 1'b0;
    impl_cfg      = impl;
    force_cfg     = force_on;
    max_fails_cfg = max_f;
  endtask

  // often follows the recommended action, with plausible events and noise
  task automatic random_event(output logic [4:0] o, output logic [3:0] a, output logic f);
    int      pick;
    action_t hint;
    pick = $urandom_range(99);
    hint = choose_action();
    o = OP_QUERY;
    a = 4'($urandom_range(15));
    f = 1'($urandom_range(1));
    if (pick < 10) begin
      o = 5'($urandom_range(31));
    end else if (pick < 55 && hint != ACT_NONE) begin
      o = OP_PERFORM;
      a = hint;
    end else if (surf_st == SURF_CREATING && pick < 75) begin
      o = OP_SURFACE_MADE;
    end else if (commit_st == CP_IN_PROGRESS && pick < 75) begin
      o = OP_FINISH_COMMIT;
    end else begin
      case ($urandom_range(13))
        0:       o = OP_ENTER_FRAME;
        1:       o = OP_LEAVE_FRAME;
        2, 3: begin
          o = OP_DRAW_DONE;
          f = $urandom_range(9) < 6;
        end
        4:       o = OP_NEEDS_COMMIT;
        5: begin
          o = OP_VISIBLE;
          f = $urandom_range(9) != 0;
        end
        6: begin
          o = OP_CAN_DRAW;
          f = $urandom_range(9) != 0;
        end
        7:       o = OP_READY_ACTIVATE;
        8:       o = OP_NEEDS_REDRAW;
        9:       o = OP_FRAME_ABORTED;
        10:      o = OP_INCOMPLETE;
        11:      o = OP_READBACK;
        12:      o = OP_TEXTURE_REQ;
        default: begin
          if ($urandom_range(3) == 0) begin
            o = OP_SURFACE_LOST;
          end else begin
            o = OP_CAN_START;
            f = $urandom_range(9) != 0;
          end
        end
      endcase
    end
  endtask

  task automatic run_random(input int n);
    logic [4:0] o;
    logic [3:0] a;
    logic       f;
    repeat (n) begin
      random_event(o, a, f);
      send_item(o, a, f);
    end
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, ACT_NONE, 1'b0);
    send_item(OpUnknownHigh, ActUnknown, 1'b1);
    send_item(OpUnknownLow, ACT_NONE, 1'b0);
    send_item(OP_CAN_START, ACT_NONE, 1'b1);
    send_item(OP_PERFORM, ACT_CREATE_SURFACE, 1'b0);
    send_item(OP_SURFACE_MADE, ACT_NONE, 1'b0);
    send_item(OP_VISIBLE, ACT_NONE, 1'b1);
    send_item(OP_CAN_DRAW, ACT_NONE, 1'b1);
    send_item(OP_PERFORM, ACT_BEGIN_FRAME, 1'b0);
    // readback while a frame is in progress
    send_item(OP_READBACK, ACT_NONE, 1'b0);
    send_item(OP_FINISH_COMMIT, ACT_NONE, 1'b0);
    send_item(OP_PERFORM, ACT_COMMIT, 1'b0);
    send_item(OP_ENTER_FRAME, ACT_NONE, 1'b0);
    send_item(OP_PERFORM, ACT_DRAW_READBACK, 1'b0);
    send_item(OP_PERFORM, ActUnknown, 1'b1);
    send_item(OP_TEXTURE_REQ, ACT_NONE, 1'b0);
    send_item(OP_PERFORM, ACT_ACQUIRE_TEX, 1'b0);
    send_item(OP_INCOMPLETE, ACT_NONE, 1'b1);
    send_item(OP_DRAW_DONE, ACT_NONE, 1'b0);
    // aborts, the first while a commit is in progress
    send_item(OP_FRAME_ABORTED, ACT_NONE, 1'b1);
    send_item(OP_FRAME_ABORTED, ACT_NONE, 1'b0);
    send_item(OP_NEEDS_REDRAW, ACT_NONE, 1'b0);
    send_item(OP_NEEDS_COMMIT, ACT_NONE, 1'b0);
    send_item(OP_READY_ACTIVATE, ACT_NONE, 1'b0);
    send_item(OP_SURFACE_LOST, ACT_NONE, 1'b0);
    send_item(OP_LEAVE_FRAME, ACT_NONE, 1'b0);
    send_item(OP_PERFORM, ACT_NONE, 1'b1);
    settle();
  endtask

  task automatic test_fail_saturation();
    set_config(1'b0, 1'b0, FailCountMax);
    repeat (258) send_item(OP_DRAW_DONE, ACT_NONE, 1'b0);
    settle();
    // counter sits at its ceiling, which now meets the threshold
    set_config(1'b0, 1'b1, FailCountMax);
    send_item(OP_DRAW_DONE, ACT_NONE, 1'b0);
    settle();
    // zero threshold forces a redraw on every failure
    set_config(1'b1, 1'b1, 8'd0);
    send_item(OP_DRAW_DONE, ACT_NONE, 1'b0);
    send_item(OP_PERFORM, ACT_BEGIN_FRAME, 1'b0);
    send_item(OP_DRAW_DONE, ACT_NONE, 1'b0);
    settle();
  endtask

  task automatic test_random_phase(input logic impl, input logic force_on,
                                   input logic [7:0] max_f, input int idle_pct,
                                   input int stall_p);
    set_config(impl, force_on, max_f);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    run_random(50);
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fail_saturation();
    test_random_phase(1'b1, 1'b1, MaxFailsReset, 0, 0);
    test_random_phase(1'b0, 1'b1, 8'd1, 73, 0);
    test_random_phase(1'b1, 1'b0, FailCountMax, 0, 73);
    test_random_phase(1'b1, 1'b1, 8'd2, 32, 32);
    settle();
    if (mismatch_count == 0 && decisions_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
